// ===== rtl/core/median3_exponential_smoother_unit_assert.svh =====
// Assertion macros for the median-of-three smoother RTL.
// Needs clk and rst_n in the scope of each use; define NO_ASSERTIONS to drop them.
`ifndef MEDIAN3_EXPONENTIAL_SMOOTHER_UNIT_ASSERT_SVH
`define MEDIAN3_EXPONENTIAL_SMOOTHER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define M3ES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define M3ES_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define M3ES_ASSERT(lbl, prop, msg)
`define M3ES_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/core/m3es_pkg.sv =====
// Shared types, constants and the median function of the median-of-three smoother.
// No dependencies.
`timescale 1ns / 1ps
package m3es_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WEIGHT_BITS = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX   = WEIGHT_BITS'(100);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(45);

  localparam logic [1:0] FILL_FIRST    = 2'd0;
  localparam logic [1:0] FILL_LAST     = 2'd2;
  localparam logic [1:0] FILL_UNPRIMED = 2'd3;

  // weighted sum, its magnitude plus half, and that magnitude over four
  localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
  localparam int MAG_BITS    = SAMPLE_BITS + 6;
  localparam int Y_BITS      = MAG_BITS - 2;
  localparam int ROUND_HALF  = 50;
  localparam int DIV_LOW     = 25;
  localparam int RECIP_SHIFT = Y_BITS;
  localparam logic [SAMPLE_BITS-1:0] RECIP =
    SAMPLE_BITS'((64'd1 << RECIP_SHIFT) / 64'd25);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_tenths;
    sample_t previous_tenths;
  } in_item_t;

  typedef struct packed {
    sample_t result_tenths;
    logic    updated;
  } out_item_t;

  typedef struct packed {
    logic    fire;
    sample_t median;
    sample_t previous;
  } q_item_t;

  function automatic sample_t median3(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

endpackage

// ===== rtl/core/m3es_front.sv =====
// Front end: takes input beats, keeps the three-slot window and picks the median.
// Uses m3es_pkg; pushes classified items into m3es_queue.
`timescale 1ns / 1ps
`include "median3_exponential_smoother_unit_assert.svh"
module m3es_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  m3es_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output m3es_pkg::q_item_t  push_item
);
  import m3es_pkg::*;

  sample_t    window_r [3];
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       accept;
  logic       primed;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign primed     = (fill_r != FILL_UNPRIMED);

  always_comb begin
    push_item.previous = in_data.previous_tenths;
    push_item.fire     = !primed || (fill_r == FILL_LAST);
    push_item.median   = primed ? median3(window_r[0], window_r[1], in_data.sample_tenths)
                                : in_data.sample_tenths;
    if (!primed || fill_r == FILL_LAST) begin
      fill_nxt = FILL_FIRST;
    end else begin
      fill_nxt = fill_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_UNPRIMED;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (!primed || fill_r == 2'(i)) begin
          window_r[i] <= in_data.sample_tenths;
        end
      end
    end
  end

  `M3ES_ASSERT_NEXT(a_front_primed, accept, fill_r != FILL_UNPRIMED, "window not primed")

endmodule

// ===== rtl/core/m3es_queue.sv =====
// Short FIFO between the front end and the arithmetic back end.
// Uses m3es_pkg for the item type and depth.
`timescale 1ns / 1ps
`include "median3_exponential_smoother_unit_assert.svh"
module m3es_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  m3es_pkg::q_item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output m3es_pkg::q_item_t pop_item
);
  import m3es_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

  q_item_t             mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                push_fire;
  logic                pop_fire;

  assign push_ready = (cnt_r != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_BITS'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_BITS'(1);
      end
      if (push_fire && !pop_fire) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
      end else if (pop_fire && !push_fire) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `M3ES_ASSERT_NEXT(a_q_grow, push_fire && !pop_fire, cnt_r == $past(cnt_r) + CNT_BITS'(1), "queue count lost a beat")

endmodule

// ===== rtl/core/m3es_back.sv =====
// Back end: blends median and previous value, divides by 100 with rounding.
// Uses m3es_pkg; four register stages ending in the output register.
`timescale 1ns / 1ps
`include "median3_exponential_smoother_unit_assert.svh"
module m3es_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [m3es_pkg::WEIGHT_BITS-1:0]      weight,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  m3es_pkg::q_item_t                     pop_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output m3es_pkg::out_item_t                   out_data
);
  import m3es_pkg::*;

  logic                          en;
  logic signed [WEIGHT_BITS:0]   w_s;
  logic signed [WEIGHT_BITS:0]   wc_s;
  logic signed [PROD_BITS-1:0]   pa_nxt;
  logic signed [PROD_BITS-1:0]   pb_nxt;

  logic                          v1_r, fire1_r;
  sample_t                       prev1_r;
  logic signed [PROD_BITS-1:0]   pa1_r, pb1_r;

  logic signed [PROD_BITS-1:0]   num2;
  logic [PROD_BITS-1:0]          abs2;
  logic [MAG_BITS-1:0]           mag2;
  logic                          v2_r, fire2_r, neg2_r;
  sample_t                       prev2_r;
  logic [Y_BITS-1:0]             y2_r;

  logic [Y_BITS+SAMPLE_BITS-1:0] prod3;
  logic                          v3_r, fire3_r, neg3_r;
  sample_t                       prev3_r;
  logic [Y_BITS-1:0]             y3_r;
  logic [SAMPLE_BITS-1:0]        q3_r;

  logic [Y_BITS:0]               rem4;
  logic [SAMPLE_BITS-1:0]        q4;
  sample_t                       res4;

  logic                          out_valid_r;
  out_item_t                     out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    w_s    = {1'b0, weight};
    wc_s   = {1'b0, WEIGHT_MAX - weight};
    pa_nxt = w_s * pop_item.median;
    pb_nxt = wc_s * pop_item.previous;

    num2 = pa1_r + pb1_r;
    abs2 = num2[PROD_BITS-1] ? -num2 : num2;
    mag2 = MAG_BITS'(abs2) + MAG_BITS'(ROUND_HALF);

    prod3 = (Y_BITS+SAMPLE_BITS)'(y2_r) * (Y_BITS+SAMPLE_BITS)'(RECIP);

    // reciprocal estimate is low by at most one
    rem4 = {1'b0, y3_r} - (Y_BITS+1)'(q3_r) * (Y_BITS+1)'(DIV_LOW);
    q4   = q3_r + SAMPLE_BITS'(rem4 >= (Y_BITS+1)'(DIV_LOW));
    res4 = neg3_r ? -sample_t'(q4) : sample_t'(q4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fire1_r <= pop_item.fire;
      prev1_r <= pop_item.previous;
      pa1_r   <= pa_nxt;
      pb1_r   <= pb_nxt;

      fire2_r <= fire1_r;
      prev2_r <= prev1_r;
      neg2_r  <= num2[PROD_BITS-1];
      y2_r    <= mag2[MAG_BITS-1 -: Y_BITS];

      fire3_r <= fire2_r;
      prev3_r <= prev2_r;
      neg3_r  <= neg2_r;
      y3_r    <= y2_r;
      q3_r    <= prod3[RECIP_SHIFT +: SAMPLE_BITS];

      out_data_r.result_tenths <= fire3_r ? res4 : prev3_r;
      out_data_r.updated       <= fire3_r;
    end
  end

  `M3ES_ASSERT(a_back_rem, !v3_r || rem4 < (Y_BITS+1)'(2*DIV_LOW), "divide estimate out of range")
  `M3ES_ASSERT_NEXT(a_back_adv, v3_r && en, out_valid_r, "result dropped at output stage")

endmodule

// ===== rtl/core/median3_exponential_smoother_unit.sv =====
// Top level of the median-of-three exponential smoother.
// Uses m3es_pkg, m3es_front, m3es_queue and m3es_back.
`timescale 1ns / 1ps
// Takes one beat per clock while out_ready is high and returns one result
// beat per input beat, in order. Each accepted beat passes through the two-entry
// queue and the three arithmetic stages (weighted products, sum and rounding,
// reciprocal multiply for the divide by 100) before the output register. The first
// sample after reset fills the whole window; every third sample after it yields a
// new smoothed value with updated set, the others echo previous_tenths. The weight
// register resets to 45; values above 100 act as 100.
// Write it only while no beats are in flight.
module median3_exponential_smoother_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  m3es_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output m3es_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [m3es_pkg::WEIGHT_BITS-1:0]  cfg_data
);
  import m3es_pkg::*;

  logic [WEIGHT_BITS-1:0] weight_r;
  logic [WEIGHT_BITS-1:0] weight_sat;
  q_item_t                push_item;
  q_item_t                pop_item;
  logic                   push_valid, push_ready;
  logic                   pop_valid, pop_ready;

  assign cfg_ready  = 1'b1;
  assign weight_sat = (weight_r > WEIGHT_MAX) ? WEIGHT_MAX : weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight_r <= cfg_data;
    end
  end

  m3es_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  m3es_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  m3es_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .weight    (weight_sat),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
